### rtl/shell_word_splitter_assert.svh
// assertion macros for the shell word splitter checker
`ifndef SHELL_WORD_SPLITTER_ASSERT_SVH
`define SHELL_WORD_SPLITTER_ASSERT_SVH

// clocked check, quiet while reset is asserted
`define SWS_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define SWS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/sws_pkg.sv
// types, codes and constants shared by the shell word splitter files
package sws_pkg;

    localparam int MAX_RES = 4;

    localparam logic [9:0] LEN_CAP = 10'd1023;
    localparam logic [5:0] NUM_CAP = 6'd63;

    // result kinds
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;
    localparam logic [1:0] KIND_DONE = 2'd3;

    // error codes
    localparam logic [1:0] ERR_PIPE  = 2'd0;
    localparam logic [1:0] ERR_REDIR = 2'd1;
    localparam logic [1:0] ERR_QUOTE = 2'd2;

    // character codes
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_DOLLAR    = 8'h24;
    localparam logic [7:0] CH_AMP       = 8'h26;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_SEMI      = 8'h3B;
    localparam logic [7:0] CH_LT        = 8'h3C;
    localparam logic [7:0] CH_GT        = 8'h3E;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_BACKTICK  = 8'h60;
    localparam logic [7:0] CH_PIPE      = 8'h7C;

    typedef enum logic [1:0] {
        QM_NONE   = 2'd0,
        QM_SINGLE = 2'd1,
        QM_DOUBLE = 2'd2
    } quote_mode_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] arg_byte;
        logic [9:0] arg_length;
        logic [5:0] arg_number;
        logic [1:0] error_code;
        logic       last_result;
    } out_item_t;

    typedef struct packed {
        quote_mode_t quote_mode;
        logic        escape_pending;
        logic        in_argument;
        logic [9:0]  length_count;
        logic [5:0]  argument_count;
        logic        error_seen;
    } sws_state_t;

    localparam sws_state_t ST_RESET = '{
        quote_mode:     QM_NONE,
        escape_pending: 1'b0,
        in_argument:    1'b0,
        length_count:   10'd0,
        argument_count: 6'd0,
        error_seen:     1'b0
    };

    localparam out_item_t OUT_ZERO = '0;

endpackage

### rtl/shell_word_splitter.sv
// top level of the shell word splitter
//
// input channel char_valid/char_ready/char_item carries one byte of a
// command string per item, with last_char set on the final byte
// output channel res_valid/res_ready/res_item carries result items:
// argument bytes, end-of-argument marks with length, error items and
// the done item that closes each string
//
// each accepted item is parsed by the combinational sws_step and its results,
// zero to four of them, land in a four-slot result register that drains
// one item per cycle from slot zero while the receiver is ready
// latency: the first result of an item, if it yields any, is shown the
// cycle after the item is accepted
// throughput: one input item per cycle while each item yields at most one
// result and the receiver is ready; an item with more results holds the
// input until they drain, so the rate is set by the drain of the result register
// a new item is taken while the last pending result is being taken, so
// the two sides overlap
// a receiver stall simply holds the result register; input is refused
// until only one result is left and it is being taken
// reset clears the parse state and empties the result register
module shell_word_splitter
    import sws_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      char_valid,
    output logic      char_ready,
    input  in_item_t  char_item,
    output logic      res_valid,
    input  logic      res_ready,
    output out_item_t res_item
);

    // parse state
    sws_state_t st_reg;
    sws_state_t st_next;

    // pending results, slot zero is at the head
    out_item_t [MAX_RES-1:0] res_reg;
    out_item_t [MAX_RES-1:0] res_next;
    logic [2:0]              cnt_reg;
    logic [2:0]              cnt_next;

    // results of the step for the item at the input
    out_item_t [MAX_RES-1:0] step_res;
    logic [2:0]              step_count;

    logic take;
    logic accept;

    sws_step u_step (
        .st        (st_reg),
        .item      (char_item),
        .st_next   (st_next),
        .res       (step_res),
        .res_count (step_count)
    );

    assign res_valid  = cnt_reg != 3'd0;
    assign res_item   = res_reg[0];
    assign take       = res_valid && res_ready;
    // free when empty, or when the only pending item leaves this cycle
    assign char_ready = (cnt_reg == 3'd0) || (cnt_reg == 3'd1 && res_ready);
    assign accept     = char_valid && char_ready;

    always_comb
    begin
        res_next = res_reg;
        cnt_next = cnt_reg;
        if (accept)
        begin
            res_next = step_res;
            cnt_next = step_count;
        end
        else if (take)
        begin
            // shift the queue towards the head
            for (int i = 0; i < MAX_RES - 1; i++)
            begin
                res_next[i] = res_reg[i+1];
            end
            res_next[MAX_RES-1] = OUT_ZERO;
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= ST_RESET;
            cnt_reg <= 3'd0;
        end
        else
        begin
            if (accept)
            begin
                st_reg <= st_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    // result payload needs no reset
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

### rtl/sws_step.sv
// per-byte parse step: next state and the list of results for one item
module sws_step
    import sws_pkg::*;
(
    input  sws_state_t                 st,
    input  in_item_t                   item,
    output sws_state_t                 st_next,
    output out_item_t [MAX_RES-1:0]    res,
    output logic [2:0]                 res_count
);

    typedef struct packed {
        sws_state_t               st;
        out_item_t [MAX_RES-1:0]  res;
        logic [2:0]               n;
    } acc_t;

    function automatic logic dq_special(logic [7:0] c);
        return c == CH_DOLLAR || c == CH_BACKTICK || c == CH_DQUOTE ||
               c == CH_BACKSLASH || c == CH_NEWLINE;
    endfunction

    function automatic acc_t put(acc_t a, out_item_t o);
        acc_t r;
        r = a;
        r.res[r.n[1:0]] = o;
        r.n = r.n + 3'd1;
        return r;
    endfunction

    function automatic acc_t emit_byte(acc_t a, logic [7:0] b);
        acc_t r;
        r = put(a, '{kind: KIND_BYTE, arg_byte: b, arg_length: 10'd0,
                     arg_number: a.st.argument_count, error_code: 2'd0,
                     last_result: 1'b0});
        r.st.in_argument = 1'b1;
        if (r.st.length_count < LEN_CAP)
        begin
            r.st.length_count = r.st.length_count + 10'd1;
        end
        return r;
    endfunction

    function automatic acc_t end_arg(acc_t a);
        acc_t r;
        r = put(a, '{kind: KIND_END, arg_byte: 8'd0, arg_length: a.st.length_count,
                     arg_number: a.st.argument_count, error_code: 2'd0,
                     last_result: 1'b0});
        if (r.st.argument_count < NUM_CAP)
        begin
            r.st.argument_count = r.st.argument_count + 6'd1;
        end
        r.st.length_count = 10'd0;
        r.st.in_argument  = 1'b0;
        return r;
    endfunction

    function automatic acc_t raise_err(acc_t a, logic [1:0] code);
        acc_t r;
        r = put(a, '{kind: KIND_ERR, arg_byte: 8'd0, arg_length: 10'd0,
                     arg_number: a.st.argument_count, error_code: code,
                     last_result: 1'b0});
        r.st.error_seen = 1'b1;
        return r;
    endfunction

    acc_t       a;
    logic       handled;
    logic [7:0] c;

    always_comb
    begin
        a       = '{st: st, res: '{default: OUT_ZERO}, n: 3'd0};
        handled = 1'b0;
        c       = item.char_code;

        if (!a.st.error_seen)
        begin
            if (a.st.escape_pending)
            begin
                a.st.escape_pending = 1'b0;
                if (a.st.quote_mode == QM_NONE || dq_special(c))
                begin
                    a       = emit_byte(a, c);
                    handled = 1'b1;
                end
                else
                begin
                    a = emit_byte(a, CH_BACKSLASH);
                end
            end
            if (!handled)
            begin
                priority if (a.st.quote_mode == QM_NONE)
                begin
                    priority if (c == CH_SPACE || c == CH_TAB)
                    begin
                        if (a.st.in_argument)
                        begin
                            a = end_arg(a);
                        end
                    end
                    else if (c == CH_PIPE || c == CH_SEMI)
                    begin
                        a = raise_err(a, ERR_PIPE);
                    end
                    else if (c == CH_LT || c == CH_GT || c == CH_AMP)
                    begin
                        a = raise_err(a, ERR_REDIR);
                    end
                    else if (c == CH_SQUOTE)
                    begin
                        a.st.quote_mode  = QM_SINGLE;
                        a.st.in_argument = 1'b1;
                    end
                    else if (c == CH_DQUOTE)
                    begin
                        a.st.quote_mode  = QM_DOUBLE;
                        a.st.in_argument = 1'b1;
                    end
                    else if (c == CH_BACKSLASH)
                    begin
                        a.st.escape_pending = 1'b1;
                        a.st.in_argument    = 1'b1;
                    end
                    else
                    begin
                        a = emit_byte(a, c);
                    end
                end
                else if (a.st.quote_mode == QM_DOUBLE)
                begin
                    priority if (c == CH_DQUOTE)
                    begin
                        a.st.quote_mode = QM_NONE;
                    end
                    else if (c == CH_BACKSLASH)
                    begin
                        a.st.escape_pending = 1'b1;
                    end
                    else
                    begin
                        a = emit_byte(a, c);
                    end
                end
                else
                begin
                    if (c == CH_SQUOTE)
                    begin
                        a.st.quote_mode = QM_NONE;
                    end
                    else
                    begin
                        a = emit_byte(a, c);
                    end
                end
            end
        end

        if (item.last_char)
        begin
            if (!a.st.error_seen)
            begin
                if (a.st.escape_pending)
                begin
                    a.st.escape_pending = 1'b0;
                    a = emit_byte(a, CH_BACKSLASH);
                end
                if (a.st.quote_mode != QM_NONE)
                begin
                    a = raise_err(a, ERR_QUOTE);
                end
                else if (a.st.in_argument)
                begin
                    a = end_arg(a);
                end
            end
            a = put(a, '{kind: KIND_DONE, arg_byte: 8'd0, arg_length: 10'd0,
                         arg_number: a.st.argument_count, error_code: 2'd0,
                         last_result: 1'b1});
            a.st = ST_RESET;
        end

        st_next   = a.st;
        res       = a.res;
        res_count = a.n;
    end

endmodule

### rtl/sws_checker.sv
// port-level checks for the shell word splitter, bound to the top level
`include "shell_word_splitter_assert.svh"

module sws_checker
    import sws_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      char_valid,
    input logic      char_ready,
    input in_item_t  char_item,
    input logic      res_valid,
    input logic      res_ready,
    input out_item_t res_item
);

    // nothing leaves while in reset
    `SWS_ASSERT_ALWAYS(a_quiet_in_reset, !rst_n |-> !res_valid, "result valid during reset")

    // a stalled result holds
    `SWS_ASSERT_CLK(a_hold_stalled, res_valid && !res_ready |=> res_valid && $stable(res_item), "stalled result changed")

    // the final byte always leads to at least a done item
    `SWS_ASSERT_CLK(a_last_gives_result, char_valid && char_ready && char_item.last_char |=> res_valid, "no result after final byte")

    // only the done item carries the end-of-string flag
    `SWS_ASSERT_CLK(a_last_only_done, res_valid && res_item.last_result |-> res_item.kind == KIND_DONE && res_item.arg_length == 10'd0, "end flag on a non-done item")

endmodule

bind shell_word_splitter sws_checker u_sws_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_item  (char_item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_item   (res_item)
);
